// ===== sv/swb_mwc_random_generator_core_assert.svh =====
// assertion macros for the swb/mwc generator
// no dependencies; included by the top level
`ifndef SWB_MWC_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define SWB_MWC_RANDOM_GENERATOR_CORE_ASSERT_SVH

// clocked assertion with asynchronous active-low reset and custom message
`define SWBMWC_ASSERT_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// clocked assertion with a fixed message
`define SWBMWC_ASSERT(label, clk, rst_n, prop) \
  `SWBMWC_ASSERT_MSG(label, clk, rst_n, prop, "swbmwc assertion failed")

`endif

// ===== sv/swbmwc_pkg.sv =====
// shared types and constants for the swb/mwc generator
// no dependencies
`timescale 1ns / 1ps

package swbmwc_pkg;

  localparam int unsigned WORD_W     = 32;
  localparam int unsigned OP_W       = 2;
  localparam int unsigned SEED_IDX_W = 6;

  localparam int unsigned LONG_LAG_DEF  = 37;
  localparam int unsigned SHORT_LAG_DEF = 24;

  localparam int unsigned MWC_HALF_W = 16;
  localparam logic [14:0] MWC_MULT = 15'd30903;
  localparam logic [WORD_W-1:0] MWC_SEED_MASK = 32'h0FFF_FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_SEED_LAG = 2'd0,
    OP_SEED_MWC = 2'd1,
    OP_GENERATE = 2'd2
  } op_e;

endpackage

// ===== sv/swbmwc_in_if.sv =====
// input channel: operation, seed index and seed value with valid/ready
// depends on swbmwc_pkg
`timescale 1ns / 1ps

interface swbmwc_in_if;
  import swbmwc_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       operation;
  logic [SEED_IDX_W-1:0] seed_index;
  logic [WORD_W-1:0]     seed_value;

  modport source (output valid, output operation, output seed_index, output seed_value,
                  input ready);
  modport sink   (input valid, input operation, input seed_index, input seed_value,
                  output ready);
endinterface

// ===== sv/swbmwc_out_if.sv =====
// output channel: generated random word with valid/ready
// depends on swbmwc_pkg
`timescale 1ns / 1ps

interface swbmwc_out_if;
  import swbmwc_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink   (input valid, input random_word, output ready);
endinterface

// ===== sv/swbmwc_lag_ram.sv =====
// lag word store: two registered read ports, one write port, write-to-read bypass
// depends on swbmwc_pkg
`timescale 1ns / 1ps

module swbmwc_lag_ram #(
  parameter int unsigned Depth = swbmwc_pkg::LONG_LAG_DEF,
  parameter int unsigned IdxW  = $clog2(swbmwc_pkg::LONG_LAG_DEF)
) (
  input  logic                            clk_i,
  input  logic                            rd_en_i,
  input  logic [IdxW-1:0]                 rd_s_addr_i,
  input  logic [IdxW-1:0]                 rd_l_addr_i,
  output logic [swbmwc_pkg::WORD_W-1:0]   rd_s_data_o,
  output logic [swbmwc_pkg::WORD_W-1:0]   rd_l_data_o,
  input  logic                            we_i,
  input  logic [IdxW-1:0]                 waddr_i,
  input  logic [swbmwc_pkg::WORD_W-1:0]   wdata_i
);
  import swbmwc_pkg::*;

  logic [WORD_W-1:0] mem [Depth];
  logic [WORD_W-1:0] rd_s_q;
  logic [WORD_W-1:0] rd_l_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_s_q <= (we_i && (waddr_i == rd_s_addr_i)) ? wdata_i : mem[rd_s_addr_i];
      rd_l_q <= (we_i && (waddr_i == rd_l_addr_i)) ? wdata_i : mem[rd_l_addr_i];
    end
  end

  assign rd_s_data_o = rd_s_q;
  assign rd_l_data_o = rd_l_q;

endmodule

// ===== sv/swbmwc_step_unit.sv =====
// one generator step: subtract with borrow, mwc update and final sum
// depends on swbmwc_pkg
`timescale 1ns / 1ps

module swbmwc_step_unit (
  input  logic [swbmwc_pkg::WORD_W-1:0] xs_i,
  input  logic [swbmwc_pkg::WORD_W-1:0] xl_i,
  input  logic                          borrow_i,
  input  logic [swbmwc_pkg::WORD_W-1:0] mwc_i,
  output logic [swbmwc_pkg::WORD_W-1:0] t_o,
  output logic                          borrow_o,
  output logic [swbmwc_pkg::WORD_W-1:0] mwc_o,
  output logic [swbmwc_pkg::WORD_W-1:0] word_o
);
  import swbmwc_pkg::*;

  logic [WORD_W-2:0] prod;
  logic [WORD_W-1:0] t;
  logic [WORD_W-1:0] mwc_next;

  always_comb begin
    t        = xs_i - xl_i - {{(WORD_W-1){1'b0}}, borrow_i};
    prod     = (WORD_W-1)'(mwc_i[MWC_HALF_W-1:0]) * (WORD_W-1)'(MWC_MULT);
    mwc_next = {1'b0, prod} + {{MWC_HALF_W{1'b0}}, mwc_i[WORD_W-1:MWC_HALF_W]};
  end

  assign t_o      = t;
  assign borrow_o = (xs_i < t);
  assign mwc_o    = mwc_next;
  assign word_o   = t + mwc_next;

endmodule

// ===== sv/swb_mwc_random_generator_core.sv =====
// swb(long/short lag) plus mwc random word generator, top level
// a generate reads the lag store at accept; its word then passes the output register
// throughput: one item per cycle; set by the lag store (two reads, one write per cycle)
// items of any operation follow back to back; only a stalled output holds the input
// reset: borrow 1, mwc 1, indices at their start; lag store holds nothing until seeded
`timescale 1ns / 1ps

module swb_mwc_random_generator_core #(
  parameter int unsigned LONG_LAG  = swbmwc_pkg::LONG_LAG_DEF,
  parameter int unsigned SHORT_LAG = swbmwc_pkg::SHORT_LAG_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  swbmwc_in_if.sink    in_i,
  swbmwc_out_if.source out_o
);
  import swbmwc_pkg::*;
  `include "swb_mwc_random_generator_core_assert.svh"

  localparam int unsigned IdxW = (LONG_LAG > 1) ? $clog2(LONG_LAG) : 1;
  localparam logic [IdxW-1:0] LastIdx   = IdxW'(LONG_LAG - 1);
  localparam logic [IdxW-1:0] ShortInit = IdxW'((SHORT_LAG - 1) % LONG_LAG);
  localparam logic [SEED_IDX_W:0] LagCnt = (SEED_IDX_W + 1)'(LONG_LAG);
  localparam logic [SEED_IDX_W-1:0] OddIdx  = SEED_IDX_W'(1);
  localparam logic [SEED_IDX_W-1:0] EvenIdx = SEED_IDX_W'(2);

  function automatic logic [IdxW-1:0] step_down(input logic [IdxW-1:0] idx);
    return (idx == '0) ? LastIdx : idx - IdxW'(1);
  endfunction

  logic                  accept;
  logic                  in_ready;
  logic                  is_gen;
  logic                  out_free;

  logic [IdxW-1:0]       lidx_q, lidx_d;
  logic [IdxW-1:0]       sidx_q, sidx_d;

  logic                  b_valid_q;
  logic [OP_W-1:0]       b_op_q;
  logic [SEED_IDX_W-1:0] b_idx_q;
  logic [WORD_W-1:0]     b_val_q;
  logic [IdxW-1:0]       b_lidx_q;

  logic                  borrow_q, borrow_d;
  logic [WORD_W-1:0]     mwc_q, mwc_d;

  logic                  out_valid_q;
  logic [WORD_W-1:0]     out_word_q;

  logic [WORD_W-1:0]     xs, xl;
  logic [WORD_W-1:0]     t, mwc_next, word;
  logic                  borrow_next;

  logic                  seed_lag_ok;
  logic [WORD_W-1:0]     seed_word;
  logic                  we;
  logic [IdxW-1:0]       waddr;
  logic [WORD_W-1:0]     wdata;

  // handshake
  assign is_gen   = b_valid_q && (b_op_q == OP_GENERATE);
  assign out_free = !out_valid_q || out_o.ready;
  assign in_ready = !is_gen || out_free;
  assign accept   = in_i.valid && in_ready;
  assign in_i.ready = in_ready;

  // index update at accept
  always_comb begin
    lidx_d = lidx_q;
    sidx_d = sidx_q;
    if (accept) begin
      unique case (in_i.operation)
        OP_GENERATE: begin
          lidx_d = step_down(lidx_q);
          sidx_d = step_down(sidx_q);
        end
        OP_SEED_MWC: begin
          lidx_d = LastIdx;
          sidx_d = ShortInit;
        end
        default: begin
          lidx_d = lidx_q;
          sidx_d = sidx_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lidx_q <= LastIdx;
      sidx_q <= ShortInit;
    end else begin
      lidx_q <= lidx_d;
      sidx_q <= sidx_d;
    end
  end

  // compute stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (in_ready) begin
      b_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b_op_q   <= in_i.operation;
      b_idx_q  <= in_i.seed_index;
      b_val_q  <= in_i.seed_value;
      b_lidx_q <= lidx_q;
    end
  end

  swbmwc_lag_ram #(
    .Depth (LONG_LAG),
    .IdxW  (IdxW)
  ) u_lag_ram (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_s_addr_i (sidx_q),
    .rd_l_addr_i (lidx_q),
    .rd_s_data_o (xs),
    .rd_l_data_o (xl),
    .we_i        (we),
    .waddr_i     (waddr),
    .wdata_i     (wdata)
  );

  swbmwc_step_unit u_step (
    .xs_i     (xs),
    .xl_i     (xl),
    .borrow_i (borrow_q),
    .mwc_i    (mwc_q),
    .t_o      (t),
    .borrow_o (borrow_next),
    .mwc_o    (mwc_next),
    .word_o   (word)
  );

  // store write: seed words or the new lag word
  always_comb begin
    seed_lag_ok = b_valid_q && (b_op_q == OP_SEED_LAG) && ({1'b0, b_idx_q} < LagCnt);
    seed_word   = b_val_q;
    if (b_idx_q == OddIdx) begin
      seed_word = b_val_q | WORD_W'(1);
    end else if (b_idx_q == EvenIdx) begin
      seed_word = b_val_q & ~WORD_W'(1);
    end
    we    = seed_lag_ok || (is_gen && out_free);
    waddr = is_gen ? b_lidx_q : b_idx_q[IdxW-1:0];
    wdata = is_gen ? t : seed_word;
  end

  // borrow and mwc state
  always_comb begin
    borrow_d = borrow_q;
    mwc_d    = mwc_q;
    if (is_gen && out_free) begin
      borrow_d = borrow_next;
      mwc_d    = mwc_next;
    end else if (b_valid_q && (b_op_q == OP_SEED_MWC)) begin
      borrow_d = 1'b1;
      mwc_d    = (b_val_q & MWC_SEED_MASK) | WORD_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      borrow_q <= 1'b1;
      mwc_q    <= WORD_W'(1);
    end else begin
      borrow_q <= borrow_d;
      mwc_q    <= mwc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= is_gen;
    end
  end

  always_ff @(posedge clk_i) begin
    if (is_gen && out_free) begin
      out_word_q <= word;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.random_word = out_word_q;

  `SWBMWC_ASSERT(a_idx_range, clk_i, rst_ni, (lidx_q <= LastIdx) && (sidx_q <= LastIdx))
  `SWBMWC_ASSERT(a_out_from_gen, clk_i, rst_ni, $rose(out_valid_q) |-> $past(is_gen))
  `SWBMWC_ASSERT_MSG(a_gen_steps_index, clk_i, rst_ni, (accept && (in_i.operation == OP_GENERATE)) |=> (lidx_q == (($past(lidx_q) == '0) ? LastIdx : ($past(lidx_q) - IdxW'(1)))), "long index did not step down on generate")

endmodule

// ===== bench/swb_mwc_random_generator_core_test.sv =====
// self-checking bench for swb_mwc_random_generator_core: seeds the lag store and mwc word,
// generates words under random idling on both channels, then with none, and checks each against a predictor
// depends on swbmwc_pkg, swbmwc_in_if, swbmwc_out_if and the core
`timescale 1ns / 1ps

module swb_mwc_random_generator_core_test;
  import swbmwc_pkg::*;

  class word_tracker;
    logic [WORD_W-1:0]     lag_words [LONG_LAG_DEF];
    logic                  borrow;
    logic [WORD_W-1:0]     mwc;
    logic [SEED_IDX_W-1:0] long_pos;
    logic [SEED_IDX_W-1:0] short_pos;
    logic [WORD_W-1:0]     pending_words [$];
    int unsigned           mismatches;
    int unsigned           words_checked;
    int unsigned           lag_seeds;
    int unsigned           restarts;
    int unsigned           ignored;

    function new();
      foreach (lag_words[k]) lag_words[k] = '0;
      borrow        = 1'b1;
      mwc           = 32'd1;
      mismatches    = 0;
      words_checked = 0;
      lag_seeds     = 0;
      restarts      = 0;
      ignored       = 0;
      restart_lags();
    endfunction

    function void restart_lags();
      long_pos  = SEED_IDX_W'(LONG_LAG_DEF - 1);
      short_pos = SEED_IDX_W'((SHORT_LAG_DEF - 1) % LONG_LAG_DEF);
    endfunction

    function logic [SEED_IDX_W-1:0] lag_down(logic [SEED_IDX_W-1:0] pos);
      return (pos == 0) ? SEED_IDX_W'(LONG_LAG_DEF - 1) : pos - SEED_IDX_W'(1);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SEED_IDX_W-1:0] idx,
                               logic [WORD_W-1:0] val);
      logic [WORD_W-1:0] near_word;
      logic [WORD_W-1:0] far_word;
      logic [WORD_W-1:0] diff;
      case (op)
        OP_SEED_LAG: begin
          if (idx < LONG_LAG_DEF) begin
            // entry 1 kept odd, entry 2 kept even
            if (idx == 1) val[0] = 1'b1;
            else if (idx == 2) val[0] = 1'b0;
            lag_words[idx] = val;
            lag_seeds++;
          end else begin
            ignored++;
          end
        end
        OP_SEED_MWC: begin
          mwc    = (val & MWC_SEED_MASK) | 32'd1;
          borrow = 1'b1;
          restart_lags();
          restarts++;
        end
        OP_GENERATE: begin
          near_word = lag_words[short_pos];
          far_word  = lag_words[long_pos];
          diff      = near_word - far_word - WORD_W'(borrow);
          borrow    = (near_word < diff);
          lag_words[long_pos] = diff;
          long_pos  = lag_down(long_pos);
          short_pos = lag_down(short_pos);
          mwc = WORD_W'(mwc[MWC_HALF_W-1:0]) * WORD_W'(MWC_MULT) + (mwc >> MWC_HALF_W);
          pending_words.push_back(diff + mwc);
        end
        default: begin
          ignored++;
        end
      endcase
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $realtime, what);
      mismatches++;
    endtask

    task check_word(logic [WORD_W-1:0] got);
      logic [WORD_W-1:0] want;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("random_word %h with no generate pending", got));
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got !== want)
          report_mismatch($sformatf("random_word %h, expected %h (word %0d)",
                                    got, want, words_checked));
      end
    endtask
  endclass

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASE_ITEMS  = 380;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;

  swbmwc_in_if  req_if ();
  swbmwc_out_if word_if ();

  swb_mwc_random_generator_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_if),
    .out_o  (word_if)
  );

  word_tracker tracker;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;

  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) word_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (word_if.valid && word_if.ready) tracker.check_word(word_if.random_word);
      if (req_if.valid && req_if.ready)
        tracker.note_request(req_if.operation, req_if.seed_index, req_if.seed_value);
      if ((word_if.valid && word_if.ready) || (req_if.valid && req_if.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [SEED_IDX_W-1:0] idx,
                              logic [WORD_W-1:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.operation  <= op;
    req_if.seed_index <= idx;
    req_if.seed_value <= val;
    do @(posedge clk_i); while (!req_if.ready);
  endtask

  task automatic wait_drained();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_words.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    int unsigned done_items;
    int unsigned pick;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        send_request(OP_GENERATE, SEED_IDX_W'($urandom), $urandom);
        done_items++;
      end else if (pick < 88) begin
        send_request(OP_SEED_LAG, SEED_IDX_W'($urandom_range(LONG_LAG_DEF - 1)), $urandom);
        done_items++;
      end else if (pick < 91) begin
        send_request(OP_SEED_MWC, SEED_IDX_W'($urandom), $urandom);
        done_items++;
        // after some restarts, chosen at random, a full reseed in index order with random values
        if ($urandom_range(1)) begin
          for (int k = 0; k < LONG_LAG_DEF; k++)
            send_request(OP_SEED_LAG, SEED_IDX_W'(k), $urandom);
          done_items += LONG_LAG_DEF;
        end
      end else if (pick < 95) begin
        send_request(OP_UNUSED, SEED_IDX_W'($urandom), $urandom);
      end else begin
        send_request(OP_SEED_LAG, SEED_IDX_W'($urandom_range(63, LONG_LAG_DEF)), $urandom);
      end
    end
  endtask

  initial begin
    logic [WORD_W-1:0] seed_word;
    tracker           = new();
    send_idle_pct     = 27;
    recv_idle_pct     = 62;
    quiet_cycles      = 0;
    rst_ni            = 1'b0;
    req_if.valid      = 1'b0;
    req_if.operation  = OP_SEED_LAG;
    req_if.seed_index = '0;
    req_if.seed_value = '0;
    word_if.ready     = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ignored items and an mwc seed before the store is seeded
    send_request(OP_UNUSED, '0, '0);
    send_request(OP_SEED_LAG, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_SEED_LAG, SEED_IDX_W'(LONG_LAG_DEF), 32'hA5A5_5A5A);
    send_request(OP_SEED_MWC, '0, 32'hFFFF_FFFF);
    for (int k = 0; k < LONG_LAG_DEF; k++) begin
      case (k)
        0:                seed_word = 32'h0000_0000;
        1:                seed_word = 32'hFFFF_FFFE;
        2:                seed_word = 32'h0000_0001;
        LONG_LAG_DEF - 1: seed_word = 32'hFFFF_FFFF;
        default:          seed_word = $urandom;
      endcase
      send_request(OP_SEED_LAG, SEED_IDX_W'(k), seed_word);
    end
    repeat (8) send_request(OP_GENERATE, 6'h3F, 32'hFFFF_FFFF);
    send_request(OP_SEED_LAG, 6'd40, $urandom);
    send_request(OP_UNUSED, 6'h3F, 32'hFFFF_FFFF);
    send_request(OP_SEED_MWC, 6'h3F, 32'h0000_0000);
    repeat (4) send_request(OP_GENERATE, '0, '0);

    run_random(PHASE_ITEMS);
    // source holds off until every pending word is out
    wait_drained();

    send_idle_pct = 62;
    recv_idle_pct = 27;
    run_random(PHASE_ITEMS);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(PHASE_ITEMS);

    wait_drained();
    $display("checked %0d generated words; %0d lag seeds, %0d restarts, %0d ignored items",
             tracker.words_checked, tracker.lag_seeds, tracker.restarts, tracker.ignored);
    $display("idle mix sender/receiver: 27/62, then 62/27, then none; %0d mismatches",
             tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.pending_words.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== swb_mwc_random_generator_core.f =====
+incdir+sv
sv/swbmwc_pkg.sv
sv/swbmwc_in_if.sv
sv/swbmwc_out_if.sv
sv/swbmwc_lag_ram.sv
sv/swbmwc_step_unit.sv
sv/swb_mwc_random_generator_core.sv
bench/swb_mwc_random_generator_core_test.sv
